// ===== hw/rtl/bhlw_pkg.sv =====
`default_nettype none
package bhlw_pkg;

  // Fixed port widths of the channels, and the fraction bits of the elements.
  localparam int COL_BITS = 63;
  localparam int IDX_BITS = 8;
  localparam int FRAC_BITS = 10;

  // Defaults of the top-level parameters.
  localparam int DEF_MAX_BONES = 256;
  localparam int DEF_ELEMENT_BITS = 21;

  // Control that travels with one column through the multiply unit.
  typedef struct packed {
    logic       valid;
    logic       trans;
    logic [1:0] col;
  } mac_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bhlw_if.sv =====
`default_nettype none
// Input channel: one bone per item.
interface bhlw_in_if
  import bhlw_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                first_bone;
  logic [IDX_BITS-1:0] parent_index;
  logic [COL_BITS-1:0] local_col0;
  logic [COL_BITS-1:0] local_col1;
  logic [COL_BITS-1:0] local_col2;
  logic [COL_BITS-1:0] local_col3;

  modport source (output valid, first_bone, parent_index, local_col0, local_col1,
                  local_col2, local_col3, input ready);
  modport sink (input valid, first_bone, parent_index, local_col0, local_col1,
                local_col2, local_col3, output ready);
endinterface

// Output channel: one world matrix per item.
interface bhlw_out_if
  import bhlw_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [IDX_BITS-1:0] bone_index;
  logic [COL_BITS-1:0] world_col0;
  logic [COL_BITS-1:0] world_col1;
  logic [COL_BITS-1:0] world_col2;
  logic [COL_BITS-1:0] world_col3;
  logic                parent_error;

  modport source (output valid, bone_index, world_col0, world_col1, world_col2,
                  world_col3, parent_error, input ready);
  modport sink (input valid, bone_index, world_col0, world_col1, world_col2,
                world_col3, parent_error, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bone_hierarchy_local_to_world.sv =====
`default_nettype none
// Skeletal forward kinematics with 3x4 affine matrices in signed fixed point.
// Channel bone takes one bone per item in skeleton order: first_bone marks
// the root, parent_index names an earlier bone, local_col0..3 carry the
// local axes and translation. Channel world returns one item per bone with
// its number, its world matrix and parent_error for a parent that is not
// below the bone number (the local matrix is then passed through).
// World matrices are kept in one RAM by bone number; a bone's parent is read
// from it, and the four result columns are formed one per cycle by a shared
// nine-multiplier unit before the matrix is written back.
// A child bone passes the parent read, four column issues, the two-stage
// multiply drain and the write back before world.valid; a root or a bad
// parent skips the multiply unit and goes to the output register. No new
// bone starts until the last one is written back, as it may be its parent. A
// one-item input buffer takes the next bone while the current one is at work.
// Reset clears the bone counter and all handshake state; the RAM holds
// nothing valid until written. When world stalls, the finished item waits in
// the output register and the core holds its next result until it drains.
module bone_hierarchy_local_to_world
  import bhlw_pkg::*;
#(
  parameter int MAX_BONES = DEF_MAX_BONES,
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input wire logic  clk,
  input wire logic  rst,
  bhlw_in_if.sink   bone,
  bhlw_out_if.source world
);

  localparam int EB = ELEMENT_BITS;
  localparam int CB = 3 * EB;
  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int XW = (AW > IDX_BITS) ? AW : IDX_BITS;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_WAIT, S_DONE} state_t;

  // Input buffer.
  logic                buf_valid;
  logic                buf_first;
  logic [IDX_BITS-1:0] buf_parent;
  logic [CB-1:0]       buf_col [4];

  // Core state.
  state_t        state;
  logic [1:0]    cnt;
  logic [AW-1:0] next_bone;
  logic [AW-1:0] cur_idx;
  logic          cur_err;
  logic [CB-1:0] cur_local [4];
  logic [CB-1:0] wcol [4];

  // Output register.
  logic          out_valid;
  logic [XW-1:0] out_idx;
  logic          out_err;
  logic [CB-1:0] out_col [4];

  logic          take;
  logic          fire;
  logic [AW-1:0] idx_new;
  logic [XW-1:0] parent_x;
  logic          err_new;
  logic [AW:0]   idx_inc;
  logic [AW-1:0] next_bone_next;
  logic [4*CB-1:0] rdata;
  logic          we;
  mac_ctl_t      mac_ctl;
  mac_ctl_t      res_ctl;
  logic [CB-1:0] res;

  assign bone.ready = !buf_valid;
  assign take = (state == S_IDLE) && buf_valid;
  assign fire = (state == S_DONE) && (!out_valid || world.ready);
  assign we = fire;

  // Bone number, parent check and counter advance for the buffered bone.
  always_comb begin
    idx_new = buf_first ? '0 : next_bone;
    parent_x = XW'(buf_parent);
    err_new = !buf_first && (parent_x >= XW'(idx_new));
    idx_inc = (AW + 1)'(idx_new) + (AW + 1)'(1);
    next_bone_next = (idx_inc >= (AW + 1)'(MAX_BONES)) ? '0 : idx_inc[AW-1:0];
  end

  // Input buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (bone.valid && bone.ready) begin
      buf_valid <= 1'b1;
    end else if (take) begin
      buf_valid <= 1'b0;
    end
    if (bone.valid && bone.ready) begin
      buf_first <= bone.first_bone;
      buf_parent <= bone.parent_index;
      buf_col[0] <= bone.local_col0[CB-1:0];
      buf_col[1] <= bone.local_col1[CB-1:0];
      buf_col[2] <= bone.local_col2[CB-1:0];
      buf_col[3] <= bone.local_col3[CB-1:0];
    end
  end

  // World matrix store, all four columns side by side.
  bhlw_ram #(
    .WIDTH(4 * CB),
    .DEPTH(MAX_BONES),
    .AW(AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(cur_idx),
    .wdata({wcol[3], wcol[2], wcol[1], wcol[0]}),
    .re   (take),
    .raddr(parent_x[AW-1:0]),
    .rdata(rdata)
  );

  // Column issue to the multiply unit.
  always_comb begin
    mac_ctl.valid = (state == S_MUL);
    mac_ctl.trans = (cnt == 2'd3);
    mac_ctl.col = cnt;
  end

  bhlw_mac #(
    .ELEMENT_BITS(EB)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .pcol0  (rdata[0*CB +: CB]),
    .pcol1  (rdata[1*CB +: CB]),
    .pcol2  (rdata[2*CB +: CB]),
    .pcol3  (rdata[3*CB +: CB]),
    .lcol   (cur_local[cnt]),
    .res_ctl(res_ctl),
    .res    (res)
  );

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      next_bone <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            next_bone <= next_bone_next;
            cnt <= '0;
            state <= (buf_first || err_new) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          // The wait lets the last column leave the multiply unit.
          cnt <= cnt + 2'd1;
          if (cnt == 2'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fire) begin
        out_valid <= 1'b1;
      end else if (world.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (take) begin
      cur_idx <= idx_new;
      cur_err <= err_new;
      for (int c = 0; c < 4; c++) begin
        cur_local[c] <= buf_col[c];
        wcol[c] <= buf_col[c];
      end
    end else if (res_ctl.valid) begin
      wcol[res_ctl.col] <= res;
    end
    if (fire) begin
      out_idx <= XW'(cur_idx);
      out_err <= cur_err;
      for (int c = 0; c < 4; c++) begin
        out_col[c] <= wcol[c];
      end
    end
  end

  assign world.valid = out_valid;
  assign world.bone_index = out_idx[IDX_BITS-1:0];
  assign world.world_col0 = COL_BITS'(out_col[0]);
  assign world.world_col1 = COL_BITS'(out_col[1]);
  assign world.world_col2 = COL_BITS'(out_col[2]);
  assign world.world_col3 = COL_BITS'(out_col[3]);
  assign world.parent_error = out_err;

  // The store is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst) !(we && take))
    else $error("store read and write overlap");

  // Multiply results only come back while a child bone is in progress.
  a_res_in_window: assert property (@(posedge clk) disable iff (rst)
      res_ctl.valid |-> (state == S_MUL || state == S_WAIT))
    else $error("column result outside the compute window");

  // A finished bone always shows up on the output in the next cycle.
  a_fire_shows: assert property (@(posedge clk) disable iff (rst) fire |=> world.valid)
    else $error("finished bone not presented");

  // A bone with a bad parent never enters the multiply phase.
  a_err_bypass: assert property (@(posedge clk) disable iff (rst)
      (take && err_new) |=> state == S_DONE)
    else $error("bad parent bone entered compute");

endmodule
`default_nettype wire

// ===== hw/rtl/bhlw_ram.sv =====
`default_nettype none
// Simple dual-port RAM with registered read.
module bhlw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bhlw_mac.sv =====
`default_nettype none
// One world column per issue: nine products in the first stage, then
// sum, floor and saturation in the second stage.
module bhlw_mac
  import bhlw_pkg::*;
#(
  parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mac_ctl_t                  ctl,
  input  wire logic [3*ELEMENT_BITS-1:0] pcol0,
  input  wire logic [3*ELEMENT_BITS-1:0] pcol1,
  input  wire logic [3*ELEMENT_BITS-1:0] pcol2,
  input  wire logic [3*ELEMENT_BITS-1:0] pcol3,
  input  wire logic [3*ELEMENT_BITS-1:0] lcol,
  output mac_ctl_t                       res_ctl,
  output logic      [3*ELEMENT_BITS-1:0] res
);

  localparam int EB = ELEMENT_BITS;
  localparam int PW = 2 * EB;
  localparam int SW = PW + 3;
  localparam int QW = SW - FRAC_BITS;
  localparam logic signed [QW-1:0] EMAX = QW'((2 ** (EB - 1)) - 1);
  localparam logic signed [QW-1:0] EMIN = ~EMAX;

  logic signed [EB-1:0] p_el [3][3];
  logic signed [EB-1:0] t_el [3];
  logic signed [EB-1:0] l_el [3];
  logic signed [PW-1:0] prod [3][3];
  logic signed [EB-1:0] tr [3];
  mac_ctl_t             s1_ctl;
  logic signed [SW-1:0] acc [3];
  logic signed [QW-1:0] q [3];
  logic [3*EB-1:0]      sat_col;

  // Split the packed columns into signed elements.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p_el[0][r] = $signed(pcol0[r*EB +: EB]);
      p_el[1][r] = $signed(pcol1[r*EB +: EB]);
      p_el[2][r] = $signed(pcol2[r*EB +: EB]);
      t_el[r] = $signed(pcol3[r*EB +: EB]);
      l_el[r] = $signed(lcol[r*EB +: EB]);
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= ctl;
    end
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod[r][k] <= p_el[k][r] * l_el[k];
      end
      tr[r] <= ctl.trans ? t_el[r] : '0;
    end
  end

  // Sum, round toward minus infinity, saturate.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = SW'(prod[r][0]) + SW'(prod[r][1]) + SW'(prod[r][2])
             + (SW'(tr[r]) <<< FRAC_BITS);
      q[r] = QW'(acc[r] >>> FRAC_BITS);
      if (q[r] > EMAX) begin
        sat_col[r*EB +: EB] = EMAX[EB-1:0];
      end else if (q[r] < EMIN) begin
        sat_col[r*EB +: EB] = EMIN[EB-1:0];
      end else begin
        sat_col[r*EB +: EB] = q[r][EB-1:0];
      end
    end
  end

  // Result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ctl <= '0;
    end else begin
      res_ctl <= s1_ctl;
    end
    res <= sat_col;
  end

endmodule
`default_nettype wire

// ===== bench/bone_hierarchy_local_to_world_tb.sv =====
module bone_hierarchy_local_to_world_tb;
  import bhlw_pkg::*;

  localparam int EB = DEF_ELEMENT_BITS;
  localparam int NBONES = DEF_MAX_BONES;
  localparam int RANDOM_BONES = 620;
  localparam logic [EB-1:0] EMAX = {1'b0, {(EB-1){1'b1}}};
  localparam logic [EB-1:0] EMIN = {1'b1, {(EB-1){1'b0}}};
  localparam logic [EB-1:0] ONE = EB'(1 << FRAC_BITS);
  localparam logic [COL_BITS-1:0] MAXCOL = {EMAX, EMAX, EMAX};
  localparam logic [COL_BITS-1:0] MINCOL = {EMIN, EMIN, EMIN};

  // One world matrix as it leaves the block.
  typedef struct packed {
    logic [IDX_BITS-1:0] index;
    logic [COL_BITS-1:0] c0;
    logic [COL_BITS-1:0] c1;
    logic [COL_BITS-1:0] c2;
    logic [COL_BITS-1:0] c3;
    logic                err;
  } world_mat_t;

  // One bone as it enters the block; known marks a typed-in answer.
  typedef struct {
    logic                root;
    logic [IDX_BITS-1:0] parent;
    logic [COL_BITS-1:0] c0;
    logic [COL_BITS-1:0] c1;
    logic [COL_BITS-1:0] c2;
    logic [COL_BITS-1:0] c3;
    bit                  known;
    world_mat_t          answer;
  } bone_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bhlw_in_if bone ();
  bhlw_out_if world ();

  bone_hierarchy_local_to_world dut (
    .clk(clk),
    .rst(rst),
    .bone(bone.sink),
    .world(world.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: world store and next bone number.
  logic [COL_BITS-1:0] store0 [NBONES];
  logic [COL_BITS-1:0] store1 [NBONES];
  logic [COL_BITS-1:0] store2 [NBONES];
  logic [COL_BITS-1:0] store3 [NBONES];
  int unsigned next_num = 0;
  world_mat_t pending_worlds [$];
  int errors = 0;
  bit quiet = 0;
  bone_row_t rows [$];

  function automatic logic signed [EB-1:0] elem(logic [COL_BITS-1:0] col, int r);
    return col[r*EB +: EB];
  endfunction

  // Clears the unused top bits of a packed column.
  function automatic logic [COL_BITS-1:0] tidy(logic [COL_BITS-1:0] col);
    return COL_BITS'(col[3*EB-1:0]);
  endfunction

  // Floor by the fraction bits, then clamp to the element range.
  function automatic logic [EB-1:0] floor_clamp(longint acc);
    longint q;
    q = acc >>> FRAC_BITS;
    if (q > longint'($signed(EMAX))) return EMAX;
    if (q < longint'($signed(EMIN))) return EMIN;
    return q[EB-1:0];
  endfunction

  // Computes a bone's world matrix and records it in the store.
  function automatic world_mat_t chain_world(bone_row_t b);
    world_mat_t w;
    logic [COL_BITS-1:0] lc [4];
    logic [COL_BITS-1:0] pc [4];
    logic [COL_BITS-1:0] wc [4];
    int unsigned num;
    longint acc;
    num = b.root ? 0 : next_num;
    lc[0] = tidy(b.c0); lc[1] = tidy(b.c1); lc[2] = tidy(b.c2); lc[3] = tidy(b.c3);
    w.err = 1'b0;
    if (b.root) begin
      wc = lc;
    end else if (b.parent >= num) begin
      w.err = 1'b1;
      wc = lc;
    end else begin
      pc[0] = store0[b.parent]; pc[1] = store1[b.parent];
      pc[2] = store2[b.parent]; pc[3] = store3[b.parent];
      for (int c = 0; c < 4; c++) begin
        wc[c] = '0;
        for (int r = 0; r < 3; r++) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += longint'(elem(pc[k], r)) * longint'(elem(lc[c], k));
          if (c == 3) acc += longint'(elem(pc[3], r)) <<< FRAC_BITS;
          wc[c][r*EB +: EB] = floor_clamp(acc);
        end
      end
    end
    store0[num] = wc[0]; store1[num] = wc[1]; store2[num] = wc[2]; store3[num] = wc[3];
    next_num = (num + 1 >= NBONES) ? 0 : num + 1;
    w.index = num[IDX_BITS-1:0];
    w.c0 = wc[0]; w.c1 = wc[1]; w.c2 = wc[2]; w.c3 = wc[3];
    return w;
  endfunction

  function automatic logic [COL_BITS-1:0] rand_col();
    return COL_BITS'({$urandom, $urandom});
  endfunction

  // Small rotation-like values keep products mostly in range.
  function automatic logic [COL_BITS-1:0] tame_col();
    logic [COL_BITS-1:0] col;
    col = '0;
    for (int r = 0; r < 3; r++)
      col[r*EB +: EB] = EB'($signed($urandom_range(0, 2048)) - 1024);
    return col;
  endfunction

  function automatic void add_row(logic root, logic [IDX_BITS-1:0] parent,
                                  logic [COL_BITS-1:0] c0, logic [COL_BITS-1:0] c1,
                                  logic [COL_BITS-1:0] c2, logic [COL_BITS-1:0] c3,
                                  bit known, world_mat_t answer);
    bone_row_t b;
    b.root = root; b.parent = parent; b.c0 = c0; b.c1 = c1; b.c2 = c2; b.c3 = c3;
    b.known = known; b.answer = answer;
    rows.push_back(b);
  endfunction

  // Sink side: random stalls, checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      world.ready <= 1'b0;
    end else begin
      world.ready <= quiet || ($urandom_range(0, 99) >= 16);
      if (world.valid && world.ready) begin
        if (pending_worlds.size() == 0) begin
          errors++;
          $display("%0t: unexpected world item index %0d", $time, world.bone_index);
        end else begin
          world_mat_t e;
          e = pending_worlds.pop_front();
          if (world.bone_index !== e.index || world.world_col0 !== e.c0 ||
              world.world_col1 !== e.c1 || world.world_col2 !== e.c2 ||
              world.world_col3 !== e.c3 || world.parent_error !== e.err) begin
            errors++;
            $display("%0t: mismatch expected idx %0d err %b %h %h %h %h", $time,
                     e.index, e.err, e.c0, e.c1, e.c2, e.c3);
            $display("%0t:            actual idx %0d err %b %h %h %h %h", $time,
                     world.bone_index, world.parent_error, world.world_col0,
                     world.world_col1, world.world_col2, world.world_col3);
          end
        end
      end
    end
  end

  // Source side: sends queued rows with random gaps.
  initial begin
    world_mat_t z;
    world_mat_t got;
    bone_row_t b;
    int n;
    logic [COL_BITS-1:0] x0, x1, x2, x3;
    z = '0;
    bone.valid <= 1'b0;
    bone.first_bone <= 1'b0;
    bone.parent_index <= '0;
    bone.local_col0 <= '0;
    bone.local_col1 <= '0;
    bone.local_col2 <= '0;
    bone.local_col3 <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: roots pass through, bad parents flag, extremes saturate.
    x0 = COL_BITS'({$urandom, $urandom});
    got = z; got.c0 = tidy(x0); got.c1 = tidy(~x0); got.c2 = MAXCOL; got.c3 = MINCOL;
    add_row(1, 8'hFF, x0, ~x0, MAXCOL, MINCOL, 1, got);
    got = z; got.index = 1; got.err = 1; got.c0 = tidy(~x0); got.c1 = tidy(x0);
    got.c2 = MINCOL; got.c3 = MAXCOL;
    add_row(0, 8'h01, ~x0, x0, MINCOL, MAXCOL, 1, got);
    got = z; got.index = 2; got.err = 1;
    add_row(0, 8'hFF, '0, '0, '0, '0, 1, got);
    add_row(1, 8'h00, MAXCOL, MAXCOL, MAXCOL, MAXCOL, 0, z);
    add_row(0, 8'h00, MAXCOL, MAXCOL, MAXCOL, MAXCOL, 0, z);
    add_row(0, 8'h00, MINCOL, MINCOL, MINCOL, MINCOL, 0, z);
    add_row(0, 8'h01, MAXCOL, MINCOL, {63{1'b1}}, '0, 0, z);
    x1 = {3{ONE}};
    add_row(1, 8'h00, {EB'(0), EB'(0), ONE}, {EB'(0), ONE, EB'(0)},
            {ONE, EB'(0), EB'(0)}, x1, 0, z);
    add_row(0, 8'h00, {3{EB'(-1)}}, x1, {3{EB'(1)}}, {3{EB'(-3)}}, 0, z);
    add_row(0, 8'h01, tame_col(), tame_col(), tame_col(), tame_col(), 0, z);
    // Bone numbering wraps after a full store: the wrapped bone is a bad parent.
    add_row(1, 8'h00, tame_col(), tame_col(), tame_col(), tame_col(), 0, z);
    for (int i = 1; i < NBONES; i++)
      add_row(0, 8'($urandom_range(0, i - 1)), tame_col(), tame_col(), tame_col(),
              tame_col(), 0, z);
    got = z; got.err = 1;
    add_row(0, 8'h00, '0, '0, '0, '0, 1, got);
    add_row(0, 8'h00, tame_col(), tame_col(), tame_col(), tame_col(), 0, z);

    // Random part: well-formed skeletons with some bad parents and noise.
    n = 0;
    while (n < RANDOM_BONES) begin
      int len;
      len = $urandom_range(1, 40);
      add_row(1, 8'($urandom), rand_col(), rand_col(), rand_col(), rand_col(), 0, z);
      for (int i = 1; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          add_row(0, 8'($urandom_range(i, 255)), rand_col(), rand_col(), rand_col(),
                  rand_col(), 0, z);
        else if ($urandom_range(0, 3) == 0)
          add_row(0, 8'($urandom_range(0, i - 1)), rand_col(), rand_col(), rand_col(),
                  rand_col(), 0, z);
        else
          add_row(0, 8'($urandom_range(0, i - 1)), tame_col(), tame_col(), tame_col(),
                  tame_col(), 0, z);
      end
      n += len;
    end

    n = 0;
    while (rows.size() > 0) begin
      b = rows.pop_front();
      quiet = (n >= 400 && n < 600);
      while (!quiet && $urandom_range(0, 99) < 16) begin
        bone.valid <= 1'b0;
        @(posedge clk);
      end
      bone.valid <= 1'b1;
      bone.first_bone <= b.root;
      bone.parent_index <= b.parent;
      bone.local_col0 <= b.c0;
      bone.local_col1 <= b.c1;
      bone.local_col2 <= b.c2;
      bone.local_col3 <= b.c3;
      got = chain_world(b);
      if (b.known) got = b.answer;
      pending_worlds.push_back(got);
      @(posedge clk);
      while (!bone.ready) @(posedge clk);
      n++;
    end
    bone.valid <= 1'b0;

    while (pending_worlds.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("bone_hierarchy_local_to_world_tb: PASS");
    end else begin
      $display("bone_hierarchy_local_to_world_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("bone_hierarchy_local_to_world_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bhlw_pkg.sv
hw/rtl/bhlw_if.sv
hw/rtl/bhlw_ram.sv
hw/rtl/bhlw_mac.sv
hw/rtl/bone_hierarchy_local_to_world.sv
bench/bone_hierarchy_local_to_world_tb.sv
